### hw/rtl/uhp_pkg.sv
// ----------------------------------------------------------------------------
// uhp_pkg
// Shared types and constants for the URI scheme, host and port parser.
// ----------------------------------------------------------------------------
package uhp_pkg;

  // final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SCHEME = 3'd1,
    ST_NOT_MATCH = 3'd2,
    ST_NO_SLASH1 = 3'd3,
    ST_NO_SLASH2 = 3'd4,
    ST_NO_HOST   = 3'd5,
    ST_BAD_PORT  = 3'd6
  } uhp_status_e;

  // result kind, carried on tuser
  typedef enum logic {
    KIND_HOST  = 1'b0,
    KIND_FINAL = 1'b1
  } uhp_kind_e;

  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_QMARK = 8'h3F;
  localparam logic [7:0]  CHAR_SLASH = 8'h2F;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;

  localparam logic [2:0]  SCHEME_LEN = 3'd5;
  localparam logic [16:0] PORT_OVF   = 17'h10000;
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd2917;

  // one accepted input item
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } uhp_item_t;

  // one result item
  typedef struct packed {
    logic [15:0] port_number;
    uhp_status_e status;
    logic [7:0]  host_byte;
    uhp_kind_e   kind;
  } uhp_result_t;

  // expected scheme text, one character per position
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        3'd0:    c = 8'h65;  // e
        3'd1:    c = 8'h6C;  // l
        3'd2:    c = 8'h76;  // v
        3'd3:    c = 8'h69;  // i
        3'd4:    c = 8'h6E;  // n
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

### hw/rtl/uhp_in_stage.sv
// ----------------------------------------------------------------------------
// uhp_in_stage
// Input register: holds one accepted character request for the parse core.
// ----------------------------------------------------------------------------
module uhp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uhp_pkg::uhp_item_t in_item_i,
  output logic               item_valid_o,
  input  logic               item_take_i,
  output uhp_pkg::uhp_item_t item_o
);
  import uhp_pkg::*;

  logic      valid_q, valid_d;
  uhp_item_t item_q;

  // free when empty or when the held request leaves this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // control flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/uhp_core.sv
// ----------------------------------------------------------------------------
// uhp_core
// Parse state and result register: one character per cycle, unless stalled,
// updates the phase, scheme match, port accumulator and latched error, and
// loads a host character or final result into the output register.
// ----------------------------------------------------------------------------
module uhp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_take_o,
  input  uhp_pkg::uhp_item_t   item_i,
  input  logic [15:0]          default_port_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output uhp_pkg::uhp_result_t res_o
);
  import uhp_pkg::*;

  typedef enum logic [2:0] {
    PH_SCHEME    = 3'd0,
    PH_SLASH1    = 3'd1,
    PH_SLASH2    = 3'd2,
    PH_HOSTSTART = 3'd3,
    PH_HOST      = 3'd4,
    PH_PORT      = 3'd5,
    PH_TRAIL     = 3'd6,
    PH_FAILED    = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic        bad_q, bad_d;
  logic [16:0] acc_q, acc_d;
  logic        digit_q, digit_d;
  uhp_status_e fail_q, fail_d;

  logic        res_valid_q, res_valid_d;
  uhp_result_t res_q, res_d;

  logic        emit;
  logic        out_free;
  logic        is_digit;
  logic [7:0]  c;
  logic [19:0] acc_next;
  uhp_status_e fin_st;
  logic [15:0] fin_port;

  assign c        = item_i.char_byte;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  // acc * 10 + digit, only used while acc holds no overflow mark
  assign acc_next = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {12'd0, c - CHAR_ZERO};

  // final status and port from the current phase
  always_comb begin
    fin_st   = ST_OK;
    fin_port = default_port_i;
    case (phase_q)
      PH_SCHEME:    fin_st = ST_NO_SCHEME;
      PH_SLASH1:    fin_st = ST_NO_SLASH1;
      PH_SLASH2:    fin_st = ST_NO_SLASH2;
      PH_HOSTSTART: fin_st = ST_NO_HOST;
      PH_HOST:      fin_st = ST_OK;
      PH_PORT: begin
        if (!digit_q || acc_q[16]) begin
          fin_st = ST_BAD_PORT;
        end else begin
          fin_port = acc_q[15:0];
        end
      end
      PH_TRAIL: begin
        if (digit_q) begin
          fin_port = acc_q[15:0];
        end
      end
      default:      fin_st = fail_q;
    endcase
    if (fin_st != ST_OK) begin
      fin_port = 16'd0;
    end
  end

  // next parse state and result for the held character
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    bad_d   = bad_q;
    acc_d   = acc_q;
    digit_d = digit_q;
    fail_d  = fail_q;
    emit    = 1'b0;
    res_d   = '0;

    if (item_i.is_end) begin
      emit              = 1'b1;
      res_d.kind        = KIND_FINAL;
      res_d.status      = fin_st;
      res_d.port_number = fin_port;
      phase_d = PH_SCHEME;
      idx_d   = 3'd0;
      bad_d   = 1'b0;
      acc_d   = '0;
      digit_d = 1'b0;
      fail_d  = ST_OK;
    end else begin
      case (phase_q)
        PH_SCHEME: begin
          if (c == CHAR_COLON) begin
            if (bad_q || idx_q != SCHEME_LEN) begin
              fail_d  = ST_NOT_MATCH;
              phase_d = PH_FAILED;
            end else begin
              phase_d = PH_SLASH1;
            end
          end else begin
            if (idx_q >= SCHEME_LEN || c != scheme_char(idx_q)) begin
              bad_d = 1'b1;
            end
            if (idx_q < SCHEME_LEN) begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
        PH_SLASH1: begin
          if (c == CHAR_SLASH) begin
            phase_d = PH_SLASH2;
          end
        end
        PH_SLASH2: begin
          if (c == CHAR_SLASH) begin
            phase_d = PH_HOSTSTART;
          end
        end
        PH_HOSTSTART, PH_HOST: begin
          if (c == CHAR_COLON || c == CHAR_QMARK) begin
            if (phase_q == PH_HOSTSTART) begin
              fail_d  = ST_NO_HOST;
              phase_d = PH_FAILED;
            end else if (c == CHAR_COLON) begin
              acc_d   = '0;
              digit_d = 1'b0;
              phase_d = PH_PORT;
            end else begin
              phase_d = PH_TRAIL;
            end
          end else begin
            phase_d         = PH_HOST;
            emit            = 1'b1;
            res_d.kind      = KIND_HOST;
            res_d.host_byte = c;
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            digit_d = 1'b1;
            if (!acc_q[16]) begin
              if (acc_next[19:16] != 4'd0) begin
                acc_d = PORT_OVF;
              end else begin
                acc_d = acc_next[16:0];
              end
            end
          end else if (!digit_q || acc_q[16]) begin
            fail_d  = ST_BAD_PORT;
            phase_d = PH_FAILED;
          end else begin
            phase_d = PH_TRAIL;
          end
        end
        default: ;
      endcase
    end
  end

  // advance when the result register can take what this character produces
  assign out_free    = !res_valid_q || res_ready_i;
  assign item_take_o = item_valid_i && (out_free || !emit);

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (item_take_o && emit) begin
      res_valid_d = 1'b1;
    end
  end

  // parse state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SCHEME;
      idx_q       <= 3'd0;
      bad_q       <= 1'b0;
      acc_q       <= '0;
      digit_q     <= 1'b0;
      fail_q      <= ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (item_take_o) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        bad_q   <= bad_d;
        acc_q   <= acc_d;
        digit_q <= digit_d;
        fail_q  <= fail_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/uri_scheme_host_port_parser.sv
// ----------------------------------------------------------------------------
// uri_scheme_host_port_parser
// Streams a URI one character per request and reports host characters and
// a final status with the port.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one URI character per request in tdata[7:0]; tlast marks
//   the terminator request, whose data byte is ignored.
//   m_axis returns zero or one result per request. tuser is the kind: 0 for a
//   host character (tdata[7:0]), 1 for the final result with status in
//   tdata[10:8] and the port in tdata[26:11].
//   cfg_we_i/cfg_wdata_i write the default port; write it only while idle.
// Timing:
//   a request is accepted into the input register, parsed by the core and
//   its result registered in the output register that drives m_axis. One
//   request per cycle is sustained while no result stalls on m_axis; the
//   parse step over the phase register and port accumulator sets that rate.
// Reset:
//   the parse restarts at the scheme, the output is empty and the default
//   port returns to 2917.
// Stall:
//   while m_axis_tready is low a held result stays; requests that give no
//   result keep flowing, and one more request waits in the input register.
// ----------------------------------------------------------------------------
module uri_scheme_host_port_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] host_byte, [10:8] status,
                                      // [26:11] port_number, [31:27] zero
  output logic        m_axis_tuser,   // [0] kind
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import uhp_pkg::*;

  logic [15:0] default_port_q;
  uhp_item_t   in_item;
  uhp_item_t   item;
  logic        item_valid;
  logic        item_take;
  uhp_result_t res;

  // default port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= DEFAULT_PORT_RST;
    end else if (cfg_we_i) begin
      default_port_q <= cfg_wdata_i;
    end
  end

  assign in_item.char_byte = s_axis_tdata;
  assign in_item.is_end    = s_axis_tlast;

  uhp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  uhp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_take_o    (item_take),
    .item_i         (item),
    .default_port_i (default_port_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_o          (res)
  );

  // pack result fields
  assign m_axis_tdata = {5'd0, res.port_number, res.status, res.host_byte};
  assign m_axis_tuser = res.kind;

endmodule

### hw/rtl/uhp_checker.sv
// ----------------------------------------------------------------------------
// uhp_checker
// Port-level checks for the URI parser, bound to the top level.
// ----------------------------------------------------------------------------
module uhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import uhp_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // host character results carry no status or port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:8] == 24'd0)
    else $error("host result with status or port");

  // final results carry no host byte and a legal status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[10:8] != 3'd7 &&
      m_axis_tdata[31:27] == 5'd0)
    else $error("malformed final result");

  // an error status reports port zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != ST_OK |->
      m_axis_tdata[26:11] == 16'd0)
    else $error("error result with nonzero port");

endmodule

bind uri_scheme_host_port_parser uhp_checker u_uhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
